// ===== rtl/core/cprt_pkg.sv =====
package cprt_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int ID_BITS     = 16;
  localparam int COUNT_BITS  = 8;

  localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(TABLE_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Result codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BEGAN = 2'd1;
  localparam logic [1:0] EV_ENDED = 2'd2;
  localparam logic [1:0] EV_FULL  = 2'd3;

  // One stored pair
  typedef struct packed {
    logic [ID_BITS-1:0]    low_id;
    logic [ID_BITS-1:0]    high_id;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a new request, restart the scan
    logic scan_en;  // read the next table entry
    logic update;   // apply the read-modify-write and emit the result
  } cprt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last; // the entry being read is the last one
  } cprt_sts_t;

endpackage

// ===== rtl/core/cprt_ctrl.sv =====
module cprt_ctrl
  import cprt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cprt_sts_t sts,
  output cprt_cmd_t cmd,
  output logic      busy
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      // last read entry is compared here
      ST_FINISH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/cprt_dp.sv =====
module cprt_dp
  import cprt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cprt_cmd_t             cmd,
  output cprt_sts_t             sts,
  input  logic                  in_is_end,
  input  logic [ID_BITS-1:0]    in_body_a,
  input  logic [ID_BITS-1:0]    in_body_b,
  output logic                  out_strobe,
  output logic [1:0]            out_event_res,
  output logic [ID_BITS-1:0]    out_pair_low,
  output logic [ID_BITS-1:0]    out_pair_high,
  output logic [COUNT_BITS-1:0] out_live_count
);

  // Table storage: valid bits in flops, pair data in a memory
  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;

  // Captured request
  logic                  is_end_r;
  logic [ID_BITS-1:0]    lo_r;
  logic [ID_BITS-1:0]    hi_r;

  // Scan pipeline
  logic [IDX_BITS-1:0]   scan_idx_r;
  entry_t                q_data_r;
  logic                  q_vld_r;
  logic [IDX_BITS-1:0]   q_idx_r;
  logic                  q_live_r;

  // Scan findings
  logic                  hit_r;
  logic [IDX_BITS-1:0]   hit_idx_r;
  logic [COUNT_BITS-1:0] hit_cnt_r;
  logic                  free_r;
  logic [IDX_BITS-1:0]   free_idx_r;

  // Result registers
  logic                  strobe_r;
  logic [1:0]            ev_r;
  logic [COUNT_BITS-1:0] live_r;

  logic                  q_match;

  // Update decision
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  set_vld;
  logic                  clr_vld;
  logic [1:0]            ev_nxt;
  logic [COUNT_BITS-1:0] live_nxt;

  assign sts.scan_last = (scan_idx_r == IDX_LAST);
  assign q_match       = q_vld_r && (q_data_r.low_id == lo_r) && (q_data_r.high_id == hi_r);

  // Request capture, ordered pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_end_r <= in_is_end;
      lo_r     <= (in_body_a < in_body_b) ? in_body_a : in_body_b;
      hi_r     <= (in_body_a < in_body_b) ? in_body_b : in_body_a;
    end
  end

  // Scan address counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_en) begin
      scan_idx_r <= scan_idx_r + IDX_BITS'(1);
    end
  end

  // Memory: registered read, single write
  always_ff @(posedge clk) begin
    q_data_r <= mem[scan_idx_r];
    q_vld_r  <= valid_r[scan_idx_r];
    q_idx_r  <= scan_idx_r;
    if (wr_en) begin
      mem[wr_idx] <= '{low_id: lo_r, high_id: hi_r, count: wr_cnt};
    end
  end

  // Compare stage: first match and lowest free entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_live_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      q_live_r <= cmd.scan_en;
      if (cmd.load) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (q_live_r) begin
        if (q_match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= q_idx_r;
          hit_cnt_r <= q_data_r.count;
        end
        if (!q_vld_r && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= q_idx_r;
        end
      end
    end
  end

  // Read-modify-write decision
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = hit_idx_r;
    wr_cnt   = hit_cnt_r;
    set_vld  = 1'b0;
    clr_vld  = 1'b0;
    ev_nxt   = EV_NONE;
    live_nxt = '0;
    if (!is_end_r) begin
      if (hit_r) begin
        // count saturates
        wr_cnt   = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + COUNT_ONE;
        wr_en    = 1'b1;
        live_nxt = wr_cnt;
      end else if (free_r) begin
        wr_idx   = free_idx_r;
        wr_cnt   = COUNT_ONE;
        wr_en    = 1'b1;
        set_vld  = 1'b1;
        ev_nxt   = EV_BEGAN;
        live_nxt = COUNT_ONE;
      end else begin
        ev_nxt = EV_FULL;
      end
    end else if (hit_r) begin
      if (hit_cnt_r <= COUNT_ONE) begin
        clr_vld = 1'b1;
        ev_nxt  = EV_ENDED;
      end else begin
        wr_cnt   = hit_cnt_r - COUNT_ONE;
        wr_en    = 1'b1;
        live_nxt = wr_cnt;
      end
    end
    wr_en   = wr_en && cmd.update;
    set_vld = set_vld && cmd.update;
    clr_vld = clr_vld && cmd.update;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (set_vld) begin
      valid_r[free_idx_r] <= 1'b1;
    end else if (clr_vld) begin
      valid_r[hit_idx_r] <= 1'b0;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.update;
    end
    if (cmd.update) begin
      ev_r   <= ev_nxt;
      live_r <= live_nxt;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_event_res  = ev_r;
  assign out_pair_low   = lo_r;
  assign out_pair_high  = hi_r;
  assign out_live_count = live_r;

endmodule

// ===== rtl/core/contact_pair_refcount_table.sv =====
// Contact pair table with reference counts. Raise start with an event while
// busy is low; the block then reads all 64 table entries one per clock
// through a single memory read port to find the pair and the lowest free
// entry, then does one read-modify-write, and the result is shown with
// out_strobe for exactly one cycle just as busy falls. The receiver cannot
// stall the result. The table comes out of reset empty with no clearing pass.
module contact_pair_refcount_table
  import cprt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_is_end,
  input  logic [ID_BITS-1:0]    in_body_a,
  input  logic [ID_BITS-1:0]    in_body_b,
  output logic                  out_strobe,
  output logic [1:0]            out_event_res,
  output logic [ID_BITS-1:0]    out_pair_low,
  output logic [ID_BITS-1:0]    out_pair_high,
  output logic [COUNT_BITS-1:0] out_live_count
);

  cprt_cmd_t cmd;
  cprt_sts_t sts;

  cprt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cprt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_is_end      (in_is_end),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_strobe     (out_strobe),
    .out_event_res  (out_event_res),
    .out_pair_low   (out_pair_low),
    .out_pair_high  (out_pair_high),
    .out_live_count (out_live_count)
  );

endmodule

// ===== tb/contact_pair_checker.sv =====
`timescale 1ns / 1ps

module contact_pair_checker
  import cprt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_is_end,
  input  logic [ID_BITS-1:0]    in_body_a,
  input  logic [ID_BITS-1:0]    in_body_b,
  input  logic                  out_strobe,
  input  logic [1:0]            out_event_res,
  input  logic [ID_BITS-1:0]    out_pair_low,
  input  logic [ID_BITS-1:0]    out_pair_high,
  input  logic [COUNT_BITS-1:0] out_live_count,
  output int unsigned           fail_count,
  output int unsigned           pending_count
);

  typedef struct {
    logic [1:0]            event_res;
    logic [ID_BITS-1:0]    pair_low;
    logic [ID_BITS-1:0]    pair_high;
    logic [COUNT_BITS-1:0] live_count;
  } pair_event_t;

  // Shadow copy of the pair table
  logic                  pair_valid   [TABLE_DEPTH];
  logic [ID_BITS-1:0]    pair_low_id  [TABLE_DEPTH];
  logic [ID_BITS-1:0]    pair_high_id [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] pair_refs    [TABLE_DEPTH];

  pair_event_t pending_pair_events[$];
  int unsigned mismatches = 0;

  assign fail_count    = mismatches;
  assign pending_count = pending_pair_events.size();

  // Work out the event a contact request causes and update the shadow table
  task automatic track_contact(input logic ending, input logic [ID_BITS-1:0] a, b,
                               output pair_event_t ev);
    logic [ID_BITS-1:0] lo;
    logic [ID_BITS-1:0] hi;
    int hit;
    int free_slot;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hit = -1;
    free_slot = -1;
    ev.event_res  = EV_NONE;
    ev.pair_low   = lo;
    ev.pair_high  = hi;
    ev.live_count = '0;
    // lowest matching entry and lowest free entry
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && pair_valid[i] && pair_low_id[i] == lo && pair_high_id[i] == hi)
        hit = i;
      if (free_slot < 0 && !pair_valid[i])
        free_slot = i;
    end
    if (!ending) begin
      if (hit >= 0) begin
        if (pair_refs[hit] != COUNT_MAX)
          pair_refs[hit] = pair_refs[hit] + COUNT_ONE;
        ev.live_count = pair_refs[hit];
      end else if (free_slot >= 0) begin
        pair_valid[free_slot]   = 1'b1;
        pair_low_id[free_slot]  = lo;
        pair_high_id[free_slot] = hi;
        pair_refs[free_slot]    = COUNT_ONE;
        ev.event_res  = EV_BEGAN;
        ev.live_count = COUNT_ONE;
      end else begin
        ev.event_res = EV_FULL;
      end
    end else if (hit >= 0) begin
      // a stored count of zero is freed just like a count of one
      if (pair_refs[hit] <= COUNT_ONE) begin
        pair_refs[hit]  = '0;
        pair_valid[hit] = 1'b0;
        ev.event_res    = EV_ENDED;
      end else begin
        pair_refs[hit] = pair_refs[hit] - COUNT_ONE;
        ev.live_count  = pair_refs[hit];
      end
    end
  endtask

  function automatic void check_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Retire results against the oldest expectation, then predict new requests
  always @(posedge clk) begin
    pair_event_t want;
    pair_event_t ev;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        pair_valid[i] = 1'b0;
      end
      pending_pair_events.delete();
    end else begin
      if (out_strobe) begin
        if (pending_pair_events.size() == 0) begin
          $error("result with no request outstanding: event %0d pair %0h/%0h count %0d",
                 out_event_res, out_pair_low, out_pair_high, out_live_count);
          mismatches++;
        end else begin
          want = pending_pair_events.pop_front();
          check_field("event_res",  32'(want.event_res),  32'(out_event_res));
          check_field("pair_low",   32'(want.pair_low),   32'(out_pair_low));
          check_field("pair_high",  32'(want.pair_high),  32'(out_pair_high));
          check_field("live_count", 32'(want.live_count), 32'(out_live_count));
        end
      end
      if (start && !busy) begin
        track_contact(in_is_end, in_body_a, in_body_b, ev);
        pending_pair_events = {pending_pair_events, ev};
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cprt_pkg::*;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_END   = 1'b1;
  localparam int   POOL_MAX = 96;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  in_is_end = 1'b0;
  logic [ID_BITS-1:0]    in_body_a = '0;
  logic [ID_BITS-1:0]    in_body_b = '0;
  logic                  busy;
  logic                  out_strobe;
  logic [1:0]            out_event_res;
  logic [ID_BITS-1:0]    out_pair_low;
  logic [ID_BITS-1:0]    out_pair_high;
  logic [COUNT_BITS-1:0] out_live_count;
  int unsigned           fail_count;
  int unsigned           pending_count;

  bit                 gaps_on = 1'b1;
  logic [ID_BITS-1:0] pool_a [POOL_MAX];
  logic [ID_BITS-1:0] pool_b [POOL_MAX];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  contact_pair_refcount_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_is_end      (in_is_end),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_strobe     (out_strobe),
    .out_event_res  (out_event_res),
    .out_pair_low   (out_pair_low),
    .out_pair_high  (out_pair_high),
    .out_live_count (out_live_count)
  );

  contact_pair_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_is_end      (in_is_end),
    .in_body_a      (in_body_a),
    .in_body_b      (in_body_b),
    .out_strobe     (out_strobe),
    .out_event_res  (out_event_res),
    .out_pair_low   (out_pair_low),
    .out_pair_high  (out_pair_high),
    .out_live_count (out_live_count),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // Issue one request; called and returns at a rising edge
  task automatic send_contact(input logic op, input logic [ID_BITS-1:0] a, b);
    // occasional gap once the block is free, with junk on the fields while start is low
    if (gaps_on && $urandom_range(99) < 13) begin
      start     <= 1'b0;
      in_is_end <= 1'($urandom);
      in_body_a <= ID_BITS'($urandom);
      in_body_b <= ID_BITS'($urandom);
      @(negedge clk);
      while (busy) @(negedge clk);
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end
    start     <= 1'b1;
    in_is_end <= op;
    in_body_a <= a;
    in_body_b <= b;
    // busy is stable mid-cycle; low there means the next edge takes the request
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic fill_pool(input int n);
    for (int i = 0; i < n; i++) begin
      pool_a[i] = ID_BITS'($urandom);
      pool_b[i] = ($urandom_range(9) == 0) ? pool_a[i] : ID_BITS'($urandom);
    end
  endtask

  // Random traffic over a pool of pairs, either id order, with some stray pairs
  task automatic run_pool(input int count, input int n, input int end_pct,
                          input int noise_pct);
    int  k;
    logic op;
    repeat (count) begin
      k  = $urandom_range(n - 1);
      op = ($urandom_range(99) < end_pct) ? OP_END : OP_BEGIN;
      if ($urandom_range(99) < noise_pct)
        send_contact(op, ID_BITS'($urandom), ID_BITS'($urandom));
      else if ($urandom_range(1) == 1)
        send_contact(op, pool_a[k], pool_b[k]);
      else
        send_contact(op, pool_b[k], pool_a[k]);
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: id extremes, ordering, equal ids, absent ends, begin/end on live pairs
    send_contact(OP_BEGIN, 16'h0000, 16'h0000);
    send_contact(OP_BEGIN, 16'hFFFF, 16'h0000);
    send_contact(OP_BEGIN, 16'h0000, 16'hFFFF);
    send_contact(OP_BEGIN, 16'hFFFF, 16'hFFFF);
    send_contact(OP_END,   16'h1234, 16'h4321);
    send_contact(OP_END,   16'hFFFF, 16'h0000);
    send_contact(OP_END,   16'h0000, 16'hFFFF);
    send_contact(OP_END,   16'h0000, 16'hFFFF);
    send_contact(OP_END,   16'h0000, 16'h0000);
    send_contact(OP_BEGIN, 16'h5555, 16'hAAAA);
    send_contact(OP_BEGIN, 16'hAAAA, 16'h5555);
    send_contact(OP_BEGIN, 16'h8000, 16'h7FFF);
    send_contact(OP_END,   16'h5555, 16'hAAAA);
    send_contact(OP_BEGIN, 16'h0001, 16'h8000);
    send_contact(OP_END,   16'hAAAA, 16'h5555);
    send_contact(OP_END,   16'h7FFF, 16'h8000);
    send_contact(OP_END,   16'h8000, 16'h0001);
    send_contact(OP_END,   16'hFFFF, 16'hFFFF);
    send_contact(OP_END,   16'hFFFF, 16'hFFFF);

    // Saturate one pair, then count it back down past zero; no gaps here
    gaps_on = 1'b0;
    fill_pool(1);
    run_pool(270, 1, 0, 0);
    run_pool(256, 1, 100, 0);
    gaps_on = 1'b1;

    // Busy small set of pairs, table never full
    fill_pool(16);
    run_pool(600, 16, 45, 10);

    // More distinct pairs than entries: drives the table full
    fill_pool(POOL_MAX);
    run_pool(450, POOL_MAX, 25, 5);

    // Mostly ends: frees entries and hits absent pairs
    run_pool(250, POOL_MAX, 85, 5);

    start <= 1'b0;

    // Drain, then allow for a request's full latency
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending_count != 0 && waited < 2000);
    repeat (80) @(negedge clk);
    if (pending_count != 0)
      $error("%0d expected results never arrived", pending_count);

    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
